// ----- rtl/dss_pkg.sv -----
package dss_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] POL_FIFO  = 3'd0;
    localparam logic [2:0] POL_SSTF  = 3'd1;
    localparam logic [2:0] POL_LOOK  = 3'd2;
    localparam logic [2:0] POL_CLOOK = 3'd3;
    localparam logic [2:0] POL_FLOOK = 3'd4;

    localparam logic [1:0] STAT_ADDED   = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_GRANTED = 2'd2;
    localparam logic [1:0] STAT_NONE    = 2'd3;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_PICK = 1'b1;

    typedef logic [15:0] word_t;

endpackage

// ----- rtl/disk_seek_scheduler_core.sv -----
// An add passes S_ADD and S_RESULT after accept. A pick on a non-empty queue passes
// S_SCAN (one entry per step, up to QUEUE_DEPTH, stopping early on a match), S_DECIDE,
// S_REMOVE and S_RESULT, with the S_CHECK group scan first under FLOOK. One request at
// a time; one shared distance compare per cycle. S_RESULT waits while out_stall holds.
// Reset (rst_n low, async): queue empty, policy FIFO, active group 0, sweep up.
module disk_seek_scheduler_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  dss_pkg::word_t       req_id,
    input  dss_pkg::word_t       req_track,
    input  dss_pkg::word_t       head_track,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output dss_pkg::word_t       grant_id,
    output dss_pkg::word_t       grant_track
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_REMOVE = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    localparam int IW = dss_pkg::IDX_W;
    localparam int CW = dss_pkg::CNT_W;

    dss_pkg::word_t entry_track_reg [dss_pkg::QUEUE_DEPTH];
    dss_pkg::word_t entry_ident_reg [dss_pkg::QUEUE_DEPTH];
    logic           entry_group_reg [dss_pkg::QUEUE_DEPTH];

    logic [2:0]     state_reg, state_next;
    logic [2:0]     policy_reg, policy_next;
    logic           active_reg, active_next;
    logic           sweep_up_reg, sweep_up_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  idx_reg, idx_next;

    logic           mode_reg;
    dss_pkg::word_t rid_reg, rtrk_reg, head_reg;

    logic           have_up_reg, have_up_next;
    logic           have_dn_reg, have_dn_next;
    logic           found_reg, found_next;
    dss_pkg::word_t up_d_reg, up_d_next, dn_d_reg, dn_d_next;
    logic [IW-1:0]  up_i_reg, up_i_next, dn_i_reg, dn_i_next;
    dss_pkg::word_t up_id_reg, up_id_next, up_trk_reg, up_trk_next;
    dss_pkg::word_t dn_id_reg, dn_id_next, dn_trk_reg, dn_trk_next;
    logic [IW-1:0]  sel_i_reg, sel_i_next;
    dss_pkg::word_t sel_id_reg, sel_id_next, sel_trk_reg, sel_trk_next;
    logic [1:0]     res_reg, res_next;

    logic           out_valid_reg, out_valid_next;
    logic [1:0]     status_reg, status_next;
    dss_pkg::word_t grant_id_reg, grant_id_next, grant_track_reg, grant_track_next;

    logic           accept;
    logic           pol_sstf, pol_clook, pol_flook, pol_fifo;
    dss_pkg::word_t cur_trk, cur_id, seek_dist, cmp_ref;
    logic           cur_grp, trk_gt, trk_eq, dist_lt, dist_gt, last, eligible;
    logic           do_add, do_remove;
    logic [CW-1:0]  count_m1;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign grant_id    = grant_id_reg;
    assign grant_track = grant_track_reg;

    assign pol_sstf  = (policy_reg == dss_pkg::POL_SSTF);
    assign pol_clook = (policy_reg == dss_pkg::POL_CLOOK);
    assign pol_flook = (policy_reg == dss_pkg::POL_FLOOK);
    assign pol_fifo  = !(pol_sstf || pol_clook || pol_flook
                         || (policy_reg == dss_pkg::POL_LOOK));

    // shared scan datapath
    assign cur_trk   = entry_track_reg[idx_reg];
    assign cur_id    = entry_ident_reg[idx_reg];
    assign cur_grp   = entry_group_reg[idx_reg];
    assign trk_gt    = (cur_trk > head_reg);
    assign trk_eq    = (cur_trk == head_reg);
    assign seek_dist = trk_gt ? (cur_trk - head_reg) : (head_reg - cur_trk);
    assign cmp_ref   = (trk_gt || pol_sstf) ? up_d_reg : dn_d_reg;
    assign dist_lt   = (seek_dist < cmp_ref);
    assign dist_gt   = (seek_dist > cmp_ref);
    assign count_m1  = count_reg - CW'(1);
    assign last      = ({{(CW-IW){1'b0}}, idx_reg} == count_m1);
    assign eligible  = !(pol_flook && (cur_grp != active_reg));

    assign do_add    = (state_reg == S_ADD) && (count_reg != CW'(dss_pkg::QUEUE_DEPTH));
    assign do_remove = (state_reg == S_REMOVE);

    always_comb
    begin
        state_next       = state_reg;
        policy_next      = policy_reg;
        active_next      = active_reg;
        sweep_up_next    = sweep_up_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        have_up_next     = have_up_reg;
        have_dn_next     = have_dn_reg;
        found_next       = found_reg;
        up_d_next        = up_d_reg;
        up_i_next        = up_i_reg;
        up_id_next       = up_id_reg;
        up_trk_next      = up_trk_reg;
        dn_d_next        = dn_d_reg;
        dn_i_next        = dn_i_reg;
        dn_id_next       = dn_id_reg;
        dn_trk_next      = dn_trk_reg;
        sel_i_next       = sel_i_reg;
        sel_id_next      = sel_id_reg;
        sel_trk_next     = sel_trk_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        grant_id_next    = grant_id_reg;
        grant_track_next = grant_track_reg;

        if (cfg_valid)
        begin
            policy_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next     = '0;
                have_up_next = 1'b0;
                have_dn_next = 1'b0;
                found_next   = 1'b0;
                if (accept)
                begin
                    if (mode == dss_pkg::MODE_ADD)
                    begin
                        state_next = S_ADD;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next   = dss_pkg::STAT_NONE;
                        state_next = S_RESULT;
                    end
                    else if (pol_flook)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_ADD:
            begin
                if (do_add)
                begin
                    count_next = count_reg + CW'(1);
                    res_next   = dss_pkg::STAT_ADDED;
                end
                else
                begin
                    res_next = dss_pkg::STAT_FULL;
                end
                state_next = S_RESULT;
            end
            S_CHECK:
            begin
                // FLOOK: flip groups when the active one is empty
                if (cur_grp == active_reg)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else if (last)
                begin
                    active_next   = !active_reg;
                    sweep_up_next = 1'b1;
                    idx_next      = '0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_SCAN:
            begin
                if (eligible && (pol_fifo || (!pol_sstf && trk_eq)))
                begin
                    found_next   = 1'b1;
                    sel_i_next   = idx_reg;
                    sel_id_next  = cur_id;
                    sel_trk_next = cur_trk;
                end
                else if (eligible && (pol_sstf || trk_gt))
                begin
                    if (!have_up_reg || dist_lt)
                    begin
                        have_up_next = 1'b1;
                        up_d_next    = seek_dist;
                        up_i_next    = idx_reg;
                        up_id_next   = cur_id;
                        up_trk_next  = cur_trk;
                    end
                end
                else if (eligible)
                begin
                    if (!have_dn_reg || (pol_clook ? dist_gt : dist_lt))
                    begin
                        have_dn_next = 1'b1;
                        dn_d_next    = seek_dist;
                        dn_i_next    = idx_reg;
                        dn_id_next   = cur_id;
                        dn_trk_next  = cur_trk;
                    end
                end
                if (last || (eligible && (pol_fifo || (!pol_sstf && trk_eq))))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DECIDE:
            begin
                found_next   = 1'b1;
                state_next   = S_REMOVE;
                if (!found_reg)
                begin
                    if (pol_sstf || pol_clook)
                    begin
                        if (have_up_reg)
                        begin
                            sel_i_next   = up_i_reg;
                            sel_id_next  = up_id_reg;
                            sel_trk_next = up_trk_reg;
                        end
                        else if (pol_clook && have_dn_reg)
                        begin
                            sel_i_next   = dn_i_reg;
                            sel_id_next  = dn_id_reg;
                            sel_trk_next = dn_trk_reg;
                        end
                        else
                        begin
                            found_next = 1'b0;
                        end
                    end
                    else if (sweep_up_reg)
                    begin
                        if (have_up_reg)
                        begin
                            sel_i_next   = up_i_reg;
                            sel_id_next  = up_id_reg;
                            sel_trk_next = up_trk_reg;
                        end
                        else
                        begin
                            sweep_up_next = 1'b0;
                            sel_i_next    = dn_i_reg;
                            sel_id_next   = dn_id_reg;
                            sel_trk_next  = dn_trk_reg;
                            found_next    = have_dn_reg;
                        end
                    end
                    else
                    begin
                        if (have_dn_reg)
                        begin
                            sel_i_next   = dn_i_reg;
                            sel_id_next  = dn_id_reg;
                            sel_trk_next = dn_trk_reg;
                        end
                        else
                        begin
                            sweep_up_next = 1'b1;
                            sel_i_next    = up_i_reg;
                            sel_id_next   = up_id_reg;
                            sel_trk_next  = up_trk_reg;
                            found_next    = have_up_reg;
                        end
                    end
                end
                if (!found_next)
                begin
                    res_next   = dss_pkg::STAT_NONE;
                    state_next = S_RESULT;
                end
            end
            S_REMOVE:
            begin
                count_next = count_m1;
                res_next   = dss_pkg::STAT_GRANTED;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                    if (res_reg == dss_pkg::STAT_GRANTED)
                    begin
                        grant_id_next    = sel_id_reg;
                        grant_track_next = sel_trk_reg;
                    end
                    else
                    begin
                        grant_id_next    = '0;
                        grant_track_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= dss_pkg::POL_FIFO;
            active_reg    <= 1'b0;
            sweep_up_reg  <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            active_reg    <= active_next;
            sweep_up_reg  <= sweep_up_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        have_up_reg     <= have_up_next;
        have_dn_reg     <= have_dn_next;
        found_reg       <= found_next;
        up_d_reg        <= up_d_next;
        up_i_reg        <= up_i_next;
        up_id_reg       <= up_id_next;
        up_trk_reg      <= up_trk_next;
        dn_d_reg        <= dn_d_next;
        dn_i_reg        <= dn_i_next;
        dn_id_reg       <= dn_id_next;
        dn_trk_reg      <= dn_trk_next;
        sel_i_reg       <= sel_i_next;
        sel_id_reg      <= sel_id_next;
        sel_trk_reg     <= sel_trk_next;
        res_reg         <= res_next;
        status_reg      <= status_next;
        grant_id_reg    <= grant_id_next;
        grant_track_reg <= grant_track_next;
        if (accept)
        begin
            mode_reg <= mode;
            rid_reg  <= req_id;
            rtrk_reg <= req_track;
            head_reg <= head_track;
        end
    end

    // queue storage: append at the tail, close the gap on removal
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < dss_pkg::QUEUE_DEPTH; i++)
        begin
            if (do_add && (mode_reg == dss_pkg::MODE_ADD) && (count_reg == CW'(i)))
            begin
                entry_track_reg[i] <= rtrk_reg;
                entry_ident_reg[i] <= rid_reg;
                entry_group_reg[i] <= !active_reg;
            end
            else if (do_remove && (i + 1 < dss_pkg::QUEUE_DEPTH)
                     && (IW'(i) >= sel_i_reg))
            begin
                entry_track_reg[i] <= entry_track_reg[(i + 1) % dss_pkg::QUEUE_DEPTH];
                entry_ident_reg[i] <= entry_ident_reg[(i + 1) % dss_pkg::QUEUE_DEPTH];
                entry_group_reg[i] <= entry_group_reg[(i + 1) % dss_pkg::QUEUE_DEPTH];
            end
        end
    end

endmodule

// ----- tb/sv/disk_seek_scheduler_checker.sv -----
`timescale 1ns / 100ps

module disk_seek_scheduler_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [2:0]           cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 mode,
    input  dss_pkg::word_t       req_id,
    input  dss_pkg::word_t       req_track,
    input  dss_pkg::word_t       head_track,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           status,
    input  dss_pkg::word_t       grant_id,
    input  dss_pkg::word_t       grant_track,
    output int                   fail_count,
    output int                   outstanding
);
    import dss_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        word_t      gid;
        word_t      gtrk;
    } grant_t;

    logic [2:0] sched_policy;
    word_t      q_track [QUEUE_DEPTH];
    word_t      q_ident [QUEUE_DEPTH];
    logic       q_group [QUEUE_DEPTH];
    int         q_count;
    logic       cur_group;
    logic       sweep_up;
    grant_t     grant_q [$];
    grant_t     want;
    int         slot;
    int         k;

    initial fail_count = 0;
    initial outstanding = 0;

    // slot of the request to serve next, q_count if none
    function automatic int find_next(input word_t head);
        logic  flook;
        logic  any_active;
        logic  have_up;
        logic  have_dn;
        logic  have_best;
        int    i;
        int    up_slot;
        int    dn_slot;
        int    best_slot;
        word_t up_dist;
        word_t dn_dist;
        word_t best_dist;
        word_t seek_dist;
        flook     = (sched_policy == POL_FLOOK);
        have_up   = 1'b0;
        have_dn   = 1'b0;
        have_best = 1'b0;
        up_slot   = 0;
        dn_slot   = 0;
        best_slot = 0;
        up_dist   = '0;
        dn_dist   = '0;
        best_dist = '0;
        if (flook)
        begin
            any_active = 1'b0;
            for (i = 0; i < q_count; i++)
                if (q_group[i] == cur_group)
                    any_active = 1'b1;
            if (!any_active)
            begin
                cur_group = ~cur_group;
                sweep_up  = 1'b1;
            end
        end
        for (i = 0; i < q_count; i++)
        begin
            if (flook && q_group[i] != cur_group)
                continue;
            if (sched_policy == POL_FIFO || sched_policy > POL_FLOOK)
                return i;
            seek_dist = (q_track[i] >= head) ? q_track[i] - head : head - q_track[i];
            if (sched_policy == POL_SSTF)
            begin
                if (!have_best || seek_dist < best_dist)
                begin
                    have_best = 1'b1;
                    best_dist = seek_dist;
                    best_slot = i;
                end
            end
            else if (q_track[i] == head)
                return i;
            else if (q_track[i] > head)
            begin
                if (!have_up || seek_dist < up_dist)
                begin
                    have_up = 1'b1;
                    up_dist = seek_dist;
                    up_slot = i;
                end
            end
            else if (sched_policy == POL_CLOOK)
            begin
                // wrap target: lowest track below the head
                if (!have_dn || seek_dist > dn_dist)
                begin
                    have_dn = 1'b1;
                    dn_dist = seek_dist;
                    dn_slot = i;
                end
            end
            else
            begin
                if (!have_dn || seek_dist < dn_dist)
                begin
                    have_dn = 1'b1;
                    dn_dist = seek_dist;
                    dn_slot = i;
                end
            end
        end
        if (sched_policy == POL_SSTF)
            return have_best ? best_slot : q_count;
        if (sched_policy == POL_CLOOK)
            return have_up ? up_slot : (have_dn ? dn_slot : q_count);
        if (sweep_up)
        begin
            if (have_up)
                return up_slot;
            sweep_up = 1'b0;
            return have_dn ? dn_slot : q_count;
        end
        if (have_dn)
            return dn_slot;
        sweep_up = 1'b1;
        return have_up ? up_slot : q_count;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_policy = POL_FIFO;
            q_count      = 0;
            cur_group    = 1'b0;
            sweep_up     = 1'b1;
            grant_q.delete();
            outstanding  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                sched_policy = cfg_data;

            if (out_valid && !out_stall)
            begin
                if (grant_q.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d id %0h track %0h",
                           status, grant_id, grant_track);
                    fail_count++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (grant_id !== want.gid)
                    begin
                        $error("grant_id: expected %0h, got %0h", want.gid, grant_id);
                        fail_count++;
                    end
                    if (grant_track !== want.gtrk)
                    begin
                        $error("grant_track: expected %0h, got %0h", want.gtrk, grant_track);
                        fail_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                want.status = STAT_ADDED;
                want.gid    = '0;
                want.gtrk   = '0;
                if (mode == MODE_ADD)
                begin
                    if (q_count >= QUEUE_DEPTH)
                        want.status = STAT_FULL;
                    else
                    begin
                        q_track[q_count] = req_track;
                        q_ident[q_count] = req_id;
                        q_group[q_count] = ~cur_group;
                        q_count++;
                    end
                end
                else if (q_count == 0)
                    want.status = STAT_NONE;
                else
                begin
                    slot = find_next(head_track);
                    if (slot >= q_count)
                        want.status = STAT_NONE;
                    else
                    begin
                        want.status = STAT_GRANTED;
                        want.gid    = q_ident[slot];
                        want.gtrk   = q_track[slot];
                        for (k = slot; k + 1 < q_count; k++)
                        begin
                            q_track[k] = q_track[k + 1];
                            q_ident[k] = q_ident[k + 1];
                            q_group[k] = q_group[k + 1];
                        end
                        q_count--;
                    end
                end
                grant_q.insert(grant_q.size(), want);
            end

            outstanding = grant_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import dss_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       mode;
    word_t      req_id;
    word_t      req_track;
    word_t      head_track;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    word_t      grant_id;
    word_t      grant_track;

    int fail_count;
    int outstanding;
    int gap_pct   = 0;
    int stall_pct = 0;
    int sent_count = 0;

    word_t fill_track [16] = '{16'd0, 16'hFFFF, 16'd100, 16'd300, 16'd300, 16'd200,
                               16'd5000, 16'd100, 16'd40000, 16'd40000, 16'd0,
                               16'hFFFF, 16'd7, 16'd9, 16'd20000, 16'd20000};

    disk_seek_scheduler_core uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .req_id      (req_id),
        .req_track   (req_track),
        .head_track  (head_track),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .grant_id    (grant_id),
        .grant_track (grant_track)
    );

    disk_seek_scheduler_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .req_id      (req_id),
        .req_track   (req_track),
        .head_track  (head_track),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .grant_id    (grant_id),
        .grant_track (grant_track),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic set_idling(input int phase);
        case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 67; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 67; end
            default: begin gap_pct = 17; stall_pct = 17; end
        endcase
    endtask

    // called at a falling edge with no request in flight on the input side
    task automatic put_policy(input logic [2:0] pol);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= pol;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // valid stays high on return so the next request can follow back to back
    task automatic send_req(input logic m, input word_t id, input word_t trk,
                            input word_t head);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        req_id     <= id;
        req_track  <= trk;
        head_track <= head;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent_count++;
    endtask

    function automatic word_t track_sample(input logic narrow);
        if (!narrow)
            return word_t'($urandom_range(65535));
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'd32760 + word_t'($urandom_range(15));
        endcase
    endfunction

    initial
    begin
        int    i;
        int    seg;
        int    add_pct;
        word_t ident;
        logic  m;
        logic  narrow;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        mode       = MODE_ADD;
        req_id     = '0;
        req_track  = '0;
        head_track = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty pick, fill to full, overflow, then each policy
        set_idling(0);
        send_req(MODE_PICK, 16'hFFFF, 16'hFFFF, 16'h1234);
        ident = '0;
        for (i = 0; i < 16; i++)
        begin
            send_req(MODE_ADD, ident, fill_track[i], ~ident);
            ident = ident + 16'h1111;
        end
        send_req(MODE_ADD, 16'hABCD, 16'h5555, 16'd0);
        put_policy(POL_FIFO);
        send_req(MODE_PICK, 16'h5A5A, 16'hA5A5, 16'd0);
        put_policy(POL_SSTF);
        send_req(MODE_PICK, 16'h0, 16'h0, 16'd250);
        put_policy(POL_LOOK);
        send_req(MODE_PICK, 16'h0, 16'h0, 16'd30000);
        send_req(MODE_PICK, 16'h0, 16'h0, 16'hFFFF);
        put_policy(POL_CLOOK);
        send_req(MODE_PICK, 16'h0, 16'h0, 16'd50000);
        send_req(MODE_PICK, 16'h0, 16'h0, 16'hFFFF);
        put_policy(POL_FLOOK);
        send_req(MODE_PICK, 16'h0, 16'h0, 16'd100);
        send_req(MODE_ADD, 16'h7777, 16'd100, 16'd0);
        send_req(MODE_PICK, 16'h0, 16'h0, 16'd100);
        put_policy(3'd7);
        send_req(MODE_PICK, 16'h0, 16'h0, 16'd0);

        // random: every policy code, fill-heavy and drain-heavy mixes
        for (seg = 0; seg < 20; seg++)
        begin
            put_policy(seg < 8 ? 3'(seg) : 3'($urandom_range(7)));
            set_idling(seg % 4);
            add_pct = (seg % 3 == 0) ? 80 : ((seg % 3 == 1) ? 50 : 35);
            narrow  = seg[1];
            repeat (35)
            begin
                m = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_PICK;
                send_req(m, word_t'($urandom_range(65535)), track_sample(narrow),
                         track_sample(narrow));
            end
        end

        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        $display("Ran %0d requests across all eight policy codes, full and empty queues,",
                 sent_count);
        $display("and four sender gap / receiver stall patterns.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- disk_seek_scheduler_core.f -----
rtl/dss_pkg.sv
rtl/disk_seek_scheduler_core.sv
tb/sv/disk_seek_scheduler_checker.sv
tb/sv/tb_top.sv
